// ===== hdl/pdjv_pkg.sv =====
// Shared types and constants for the per-joint PD velocity controller.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package pdjv_pkg;

  localparam int unsigned ANGLE_W = 24;
  localparam int unsigned ERR_W   = 25;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned JOINT_W = 3;
  localparam int unsigned VEL_W   = 32;
  localparam int unsigned CIDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_PROP_GAIN         = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SPECIAL_PROP_GAIN = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SPECIAL_JOINT     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_DERIV_GAIN        = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_DEAD_BAND         = 3'd4;

  // Values after reset.
  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN         = 16'd614;
  localparam logic [GAIN_W-1:0]  RST_SPECIAL_PROP_GAIN = 16'd896;
  localparam logic [JOINT_W-1:0] RST_SPECIAL_JOINT     = 3'd5;
  localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN        = 16'd26;
  localparam logic [GAIN_W-1:0]  RST_DEAD_BAND         = 16'd128;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  special_prop_gain;
    logic [JOINT_W-1:0] special_joint;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [GAIN_W-1:0]  dead_band;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/pd_joint_velocity_control.sv =====
// Per-joint PD velocity controller with deadband: top level.
// Input register, PD datapath, error store, config registers, result register.
// Depends on pdjv_pkg, pdjv_cfg, pdjv_err_store and pdjv_calc.
//
// The block takes one joint sample per word on the slave stream and returns one
// velocity command per word on the master stream, in the same order. Each word
// carries a joint index and the measured and target angles (8 fractional bits).
// The command is the negated PD output, rounded to 8 fractional bits and
// saturated to 32 bits; tuser flags a clipped value.
// The result word is presented once the result register has caught it; the
// sample is first held in the input register. While the sample sits there,
// the input register feeds the error, both gain products and the rounding, and
// the result register catches them when it is free. Throughput is one word
// per cycle while the receiver does not stall, set by the single
// read-modify-write of the per-joint error store, which is written as a word
// leaves the input register so the next word of the same joint already sees it.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word; the slave side then stops.
// Reset clears both stages, all stored previous errors and restores the
// register defaults. Configuration words are taken at any time (cfg_ready_o is
// always high) and should only be written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module pd_joint_velocity_control #(
  parameter int unsigned NUM_JOINTS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // Slave stream: joint samples.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: joint [2:0], measured_angle [26:3], target_angle [50:27], zero [55:51]
  input  wire logic [55:0] s_axis_tdata,
  // Master stream: velocity commands.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: joint_out [2:0], velocity [34:3], zero [39:35]
  output logic [39:0]      m_axis_tdata,
  // tuser: saturated [0]
  output logic [0:0]       m_axis_tuser
);

  pdjv_pkg::cfg_t cfg;

  // Input register stage.
  logic                                   in_valid_q;
  logic [pdjv_pkg::JOINT_W-1:0]           in_joint_q;
  logic signed [pdjv_pkg::ANGLE_W-1:0]    in_meas_q;
  logic signed [pdjv_pkg::ANGLE_W-1:0]    in_targ_q;

  // Result register stage.
  logic                                   out_valid_q;
  logic [pdjv_pkg::JOINT_W-1:0]           out_joint_q;
  logic signed [pdjv_pkg::VEL_W-1:0]      out_vel_q;
  logic                                   out_sat_q;

  logic signed [pdjv_pkg::ERR_W-1:0]      prev_err;
  logic signed [pdjv_pkg::ERR_W-1:0]      err;
  logic signed [pdjv_pkg::VEL_W-1:0]      velocity;
  logic                                   saturated;

  logic out_free;
  logic advance;
  logic in_accept;

  // The result register can take a word when it is empty or being emptied.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  pdjv_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pdjv_err_store #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_err_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_joint_i (in_joint_q),
    .rd_err_o   (prev_err),
    .wr_en_i    (advance),
    .wr_joint_i (in_joint_q),
    .wr_err_i   (err)
  );

  pdjv_calc u_calc (
    .cfg_i       (cfg),
    .joint_i     (in_joint_q),
    .measured_i  (in_meas_q),
    .target_i    (in_targ_q),
    .prev_err_i  (prev_err),
    .err_o       (err),
    .velocity_o  (velocity),
    .saturated_o (saturated)
  );

  // Control flags of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_joint_q <= s_axis_tdata[2:0];
      in_meas_q  <= s_axis_tdata[26:3];
      in_targ_q  <= s_axis_tdata[50:27];
    end
    if (advance) begin
      out_joint_q <= in_joint_q;
      out_vel_q   <= velocity;
      out_sat_q   <= saturated;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_vel_q, out_joint_q};
  assign m_axis_tuser  = out_sat_q;

endmodule

`default_nettype wire

// ===== hdl/pdjv_cfg.sv =====
// Configuration register file of the PD velocity controller.
// Depends on pdjv_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module pdjv_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pdjv_pkg::CIDX_W-1:0]   cfg_index_i,
  input  wire logic [pdjv_pkg::GAIN_W-1:0]   cfg_data_i,
  output pdjv_pkg::cfg_t                     cfg_o
);

  pdjv_pkg::cfg_t cfg_q;
  pdjv_pkg::cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        pdjv_pkg::CFG_PROP_GAIN:         cfg_d.prop_gain         = cfg_data_i;
        pdjv_pkg::CFG_SPECIAL_PROP_GAIN: cfg_d.special_prop_gain = cfg_data_i;
        pdjv_pkg::CFG_SPECIAL_JOINT:
          cfg_d.special_joint = cfg_data_i[pdjv_pkg::JOINT_W-1:0];
        pdjv_pkg::CFG_DERIV_GAIN:        cfg_d.deriv_gain        = cfg_data_i;
        pdjv_pkg::CFG_DEAD_BAND:         cfg_d.dead_band         = cfg_data_i;
        default:                         cfg_d                   = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain         <= pdjv_pkg::RST_PROP_GAIN;
      cfg_q.special_prop_gain <= pdjv_pkg::RST_SPECIAL_PROP_GAIN;
      cfg_q.special_joint     <= pdjv_pkg::RST_SPECIAL_JOINT;
      cfg_q.deriv_gain        <= pdjv_pkg::RST_DERIV_GAIN;
      cfg_q.dead_band         <= pdjv_pkg::RST_DEAD_BAND;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pdjv_err_store.sv =====
// Per-joint store of the previous error, cleared at reset.
// Depends on pdjv_pkg for the joint and error widths.
`timescale 1ns / 1ps
`default_nettype none

module pdjv_err_store #(
  parameter int unsigned NUM_JOINTS = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [pdjv_pkg::JOINT_W-1:0]       rd_joint_i,
  output logic signed [pdjv_pkg::ERR_W-1:0]       rd_err_o,
  input  wire logic                               wr_en_i,
  input  wire logic [pdjv_pkg::JOINT_W-1:0]       wr_joint_i,
  input  wire logic signed [pdjv_pkg::ERR_W-1:0]  wr_err_i
);

  localparam int unsigned IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int unsigned EXT_W = pdjv_pkg::JOINT_W + 2;

  logic signed [pdjv_pkg::ERR_W-1:0] err_q [NUM_JOINTS];

  logic [EXT_W-1:0] rd_ext;
  logic [EXT_W-1:0] wr_ext;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             rd_in_range;
  logic             wr_in_range;

  assign rd_ext      = {2'b00, rd_joint_i};
  assign wr_ext      = {2'b00, wr_joint_i};
  assign rd_idx      = rd_ext[IDX_W-1:0];
  assign wr_idx      = wr_ext[IDX_W-1:0];
  assign rd_in_range = (rd_ext < EXT_W'(NUM_JOINTS));
  assign wr_in_range = (wr_ext < EXT_W'(NUM_JOINTS));

  // A joint beyond the store reads as zero and is never written.
  assign rd_err_o = rd_in_range ? err_q[rd_idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        err_q[i] <= '0;
      end
    end else if (wr_en_i && wr_in_range) begin
      err_q[wr_idx] <= wr_err_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pdjv_calc.sv =====
// PD arithmetic: error with deadband, both products, rounding and saturation.
// Depends on pdjv_pkg for widths and the cfg_t register bundle.
`timescale 1ns / 1ps
`default_nettype none

module pdjv_calc (
  input  wire pdjv_pkg::cfg_t                     cfg_i,
  input  wire logic [pdjv_pkg::JOINT_W-1:0]       joint_i,
  input  wire logic signed [pdjv_pkg::ANGLE_W-1:0] measured_i,
  input  wire logic signed [pdjv_pkg::ANGLE_W-1:0] target_i,
  input  wire logic signed [pdjv_pkg::ERR_W-1:0]  prev_err_i,
  output logic signed [pdjv_pkg::ERR_W-1:0]       err_o,
  output logic signed [pdjv_pkg::VEL_W-1:0]       velocity_o,
  output logic                                    saturated_o
);

  logic signed [24:0] err_raw;
  logic signed [25:0] err_wide;
  logic signed [25:0] band;
  logic               in_band;
  logic signed [24:0] err;
  logic signed [25:0] diff;
  logic signed [16:0] p_gain;
  logic signed [16:0] d_gain;
  logic signed [41:0] p_term;
  logic signed [42:0] d_term;
  logic signed [43:0] sum;
  logic signed [44:0] neg;
  logic               no_sat;

  assign err_raw = {measured_i[pdjv_pkg::ANGLE_W-1], measured_i}
                 - {target_i[pdjv_pkg::ANGLE_W-1], target_i};
  assign err_wide = {err_raw[24], err_raw};
  assign band     = {10'd0, cfg_i.dead_band};
  // Magnitude strictly below the band is treated as no error.
  assign in_band  = (err_wide < band) && (err_wide > -band);
  assign err      = in_band ? '0 : err_raw;
  assign err_o    = err;

  assign diff   = {err[24], err} - {prev_err_i[24], prev_err_i};
  assign p_gain = (joint_i == cfg_i.special_joint) ? {1'b0, cfg_i.special_prop_gain}
                                                   : {1'b0, cfg_i.prop_gain};
  assign d_gain = {1'b0, cfg_i.deriv_gain};
  assign p_term = p_gain * err;
  assign d_term = d_gain * diff;
  assign sum    = {{2{p_term[41]}}, p_term} + {d_term[42], d_term};
  // Negate and add half an output LSB; the shift below floors.
  assign neg    = 45'sd128 - {sum[43], sum};

  // After the shift by 8, bits 36..31 must agree for the value to fit.
  assign no_sat = (neg[44:39] == 6'b000000) || (neg[44:39] == 6'b111111);

  always_comb begin
    if (no_sat) begin
      velocity_o  = neg[39:8];
      saturated_o = 1'b0;
    end else if (neg[44]) begin
      velocity_o  = {1'b1, {(pdjv_pkg::VEL_W-1){1'b0}}};
      saturated_o = 1'b1;
    end else begin
      velocity_o  = {1'b0, {(pdjv_pkg::VEL_W-1){1'b1}}};
      saturated_o = 1'b1;
    end
  end

endmodule

`default_nettype wire
